// ===== sv/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// RAM bus self-test sequencer package
// Field widths, codes, and the command and status bundles shared between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int unsigned DATA_BITS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF = 24;

  localparam int unsigned OPERATION_W      = 1;
  localparam int unsigned READ_DATA_W      = 16;
  localparam int unsigned ACCESS_KIND_W    = 2;
  localparam int unsigned ACCESS_ADDRESS_W = 24;
  localparam int unsigned WRITE_WORD_W     = 16;
  localparam int unsigned RESULT_STATUS_W  = 2;
  localparam int unsigned FAIL_WORD_W      = 24;

  localparam int unsigned BASE_ADDRESS_W = 24;
  localparam int unsigned REGION_BYTES_W = 25;
  localparam int unsigned REG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 25;

  localparam logic [REGION_BYTES_W-1:0] REGION_BYTES_RST = 25'd65536;

  localparam logic [63:0] PAT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] PAT_5 = 64'h5555_5555_5555_5555;

  typedef enum logic [OPERATION_W-1:0] {
    OP_START = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [ACCESS_KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [RESULT_STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ADDR_FAULT = 2'd1,
    STATUS_DATA_FAULT = 2'd2
  } status_e;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_REGION_BYTES = 2'd1,
    REG_TEST_ENABLE  = 2'd2
  } reg_index_e;

  typedef enum logic [1:0] {
    OFF_ZERO,
    OFF_PROBE,
    OFF_VICTIM
  } off_sel_e;

  typedef enum logic [2:0] {
    WORD_ZERO,
    WORD_ONE,
    WORD_PAT_A,
    WORD_PAT_5,
    WORD_WALK
  } word_sel_e;

  typedef enum logic [1:0] {
    FAIL_NONE,
    FAIL_PROBE,
    FAIL_VICTIM,
    FAIL_WALK
  } fail_src_e;

  // FIRST loads the first offset (or a single one for the walk register)
  typedef enum logic [1:0] {
    STEP_HOLD,
    STEP_FIRST,
    STEP_SHIFT
  } step_e;

  typedef struct packed {
    logic      emit;
    kind_e     kind;
    off_sel_e  off_sel;
    word_sel_e word_sel;
    status_e   status;
    fail_src_e fail_src;
    logic      last;
    step_e     probe_step;
    step_e     victim_step;
    step_e     walk_step;
  } rbst_cmd_t;

  typedef struct packed {
    logic test_en;
    logic probe_in;
    logic victim_in;
    logic rd_eq_pat;
    logic rd_eq_walk;
    logic probe_eq_victim;
    logic walk_top;
    logic out_free;
  } rbst_stat_t;

endpackage

// ===== sv/rbst_in_if.sv =====
// ----------------------------------------------------------------------------
// RAM bus self-test input channel
// Start requests and returned read data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbst_in_if import rbst_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [OPERATION_W-1:0] operation;
  logic [READ_DATA_W-1:0] read_data;

  modport source (output valid, output operation, output read_data, input ready);
  modport sink (input valid, input operation, input read_data, output ready);

endinterface

// ===== sv/rbst_out_if.sv =====
// ----------------------------------------------------------------------------
// RAM bus self-test result channel
// Memory write, read and finish requests, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbst_out_if import rbst_pkg::*; ();

  logic                        valid;
  logic                        ready;
  logic [ACCESS_KIND_W-1:0]    access_kind;
  logic [ACCESS_ADDRESS_W-1:0] access_address;
  logic [WRITE_WORD_W-1:0]     write_word;
  logic [RESULT_STATUS_W-1:0]  result_status;
  logic [FAIL_WORD_W-1:0]      fail_word;
  logic                        last_of_run;

  modport source (
    output valid, output access_kind, output access_address, output write_word,
    output result_status, output fail_word, output last_of_run, input ready
  );
  modport sink (
    input valid, input access_kind, input access_address, input write_word,
    input result_status, input fail_word, input last_of_run, output ready
  );

endinterface

// ===== sv/rbst_cfg_if.sv =====
// ----------------------------------------------------------------------------
// RAM bus self-test configuration channel
// Register writes: index and data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbst_cfg_if import rbst_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [REG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink (input valid, input reg_index, input write_data, output ready);

endinterface

// ===== sv/ram_bus_self_test_sequencer.sv =====
// Timing: the first request of a run is issued from the S_FILL state that follows
//   its accepted input, then held in the result register; the run then streams one
//   request per cycle while the single result register is free. In the read loops
//   each read response is accepted, then the next read request is issued; no new
//   input is taken while the controller is still issuing a run.
// Reset: asynchronous, active low; idle, result valid cleared, result data not reset.
// ----------------------------------------------------------------------------
// RAM bus self-test sequencer
// Address-bus walking-ones test followed by a data-bus walking-one test,
// issued as memory write/read requests with returned read data compared.
// ----------------------------------------------------------------------------
module ram_bus_self_test_sequencer import rbst_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rbst_in_if.sink    in_i,
  rbst_out_if.source out_o,
  rbst_cfg_if.sink   cfg_i
);

  rbst_cmd_t  cmd;
  rbst_stat_t stat;

  rbst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  rbst_datapath #(
    .DATA_BITS (DATA_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .read_data_i (in_i.read_data),
    .cfg_i       (cfg_i),
    .out_o       (out_o)
  );

  // a request is never issued in the cycle an input is taken
  a_no_emit_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !cmd.emit)
    else $error("request issued while accepting input");

  // a start always begins a run, so no further input until it is done
  a_start_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.operation == OP_START) |=> !in_i.ready)
    else $error("input taken right after a start");

  a_finish_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.access_kind == KIND_FINISH) |-> out_o.last_of_run)
    else $error("finish result not marked last");

  a_read_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.access_kind == KIND_READ) |->
      (out_o.last_of_run && out_o.write_word == '0))
    else $error("read request not last or carries data");

endmodule

// ===== sv/rbst_ctrl.sv =====
// ----------------------------------------------------------------------------
// RAM bus self-test controller
// Sequences the address-bus and data-bus tests, one request per cycle while
// the result register is free, and decides on each returned read word.
// ----------------------------------------------------------------------------
module rbst_ctrl import rbst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rbst_in_if.sink    in_i,
  input  rbst_stat_t stat_i,
  output rbst_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAIT_HIGH,
    S_WAIT_LOW,
    S_WAIT_DATA,
    S_FILL,
    S_HIGH_ADV,
    S_VICTIM_NEXT,
    S_LOW_ADV,
    S_DATA_WRITE,
    S_DATA_READ,
    S_FINISH
  } state_e;

  state_e    state_q, state_d;
  status_e   fin_status_q, fin_status_d;
  fail_src_e fin_fail_q, fin_fail_d;
  logic      accept;

  assign in_i.ready = (state_q == S_IDLE) || (state_q == S_WAIT_HIGH) ||
                      (state_q == S_WAIT_LOW) || (state_q == S_WAIT_DATA);
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    fin_status_d = fin_status_q;
    fin_fail_d   = fin_fail_q;
    unique case (state_q) inside
      S_IDLE, S_WAIT_HIGH, S_WAIT_LOW, S_WAIT_DATA: begin
        if (accept) begin
          if (in_i.operation == OP_START) begin
            // a start abandons whatever test is running
            if (!stat_i.test_en) begin
              fin_status_d = STATUS_OK;
              fin_fail_d   = FAIL_NONE;
              state_d      = S_FINISH;
            end else begin
              cmd_o.probe_step = STEP_FIRST;
              state_d          = S_FILL;
            end
          end else begin
            case (state_q)
              S_WAIT_HIGH: begin
                if (!stat_i.rd_eq_pat) begin
                  fin_status_d = STATUS_ADDR_FAULT;
                  fin_fail_d   = FAIL_PROBE;
                  state_d      = S_FINISH;
                end else begin
                  cmd_o.probe_step = STEP_SHIFT;
                  state_d          = S_HIGH_ADV;
                end
              end
              S_WAIT_LOW: begin
                if (!stat_i.rd_eq_pat && !stat_i.probe_eq_victim) begin
                  fin_status_d = STATUS_ADDR_FAULT;
                  fin_fail_d   = FAIL_VICTIM;
                  state_d      = S_FINISH;
                end else begin
                  cmd_o.probe_step = STEP_SHIFT;
                  state_d          = S_LOW_ADV;
                end
              end
              S_WAIT_DATA: begin
                if (!stat_i.rd_eq_walk) begin
                  fin_status_d = STATUS_DATA_FAULT;
                  fin_fail_d   = FAIL_WALK;
                  state_d      = S_FINISH;
                end else if (stat_i.walk_top) begin
                  // the one has reached the top bit: data test passed
                  cmd_o.walk_step = STEP_FIRST;
                  fin_status_d    = STATUS_OK;
                  fin_fail_d      = FAIL_NONE;
                  state_d         = S_FINISH;
                end else begin
                  cmd_o.walk_step = STEP_SHIFT;
                  state_d         = S_DATA_WRITE;
                end
              end
              default: begin
                // read data while idle: drop it
              end
            endcase
          end
        end
      end
      S_FILL: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_WRITE;
          if (stat_i.probe_in) begin
            cmd_o.off_sel    = OFF_PROBE;
            cmd_o.word_sel   = WORD_PAT_A;
            cmd_o.probe_step = STEP_SHIFT;
          end else begin
            cmd_o.off_sel    = OFF_ZERO;
            cmd_o.word_sel   = WORD_PAT_5;
            cmd_o.probe_step = STEP_FIRST;
            state_d          = S_HIGH_ADV;
          end
        end
      end
      S_HIGH_ADV: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.probe_in) begin
            cmd_o.kind    = KIND_READ;
            cmd_o.off_sel = OFF_PROBE;
            cmd_o.last    = 1'b1;
            state_d       = S_WAIT_HIGH;
          end else begin
            // restore the base, then start the stuck-low pass
            cmd_o.kind        = KIND_WRITE;
            cmd_o.off_sel     = OFF_ZERO;
            cmd_o.word_sel    = WORD_PAT_A;
            cmd_o.victim_step = STEP_FIRST;
            state_d           = S_VICTIM_NEXT;
          end
        end
      end
      S_VICTIM_NEXT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_WRITE;
          if (!stat_i.victim_in) begin
            cmd_o.off_sel   = OFF_ZERO;
            cmd_o.word_sel  = WORD_ONE;
            cmd_o.walk_step = STEP_FIRST;
            state_d         = S_DATA_READ;
          end else begin
            cmd_o.off_sel    = OFF_VICTIM;
            cmd_o.word_sel   = WORD_PAT_5;
            cmd_o.probe_step = STEP_FIRST;
            state_d          = S_LOW_ADV;
          end
        end
      end
      S_LOW_ADV: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.probe_in) begin
            cmd_o.kind    = KIND_READ;
            cmd_o.off_sel = OFF_PROBE;
            cmd_o.last    = 1'b1;
            state_d       = S_WAIT_LOW;
          end else begin
            // restore the victim and advance to the next one
            cmd_o.kind        = KIND_WRITE;
            cmd_o.off_sel     = OFF_VICTIM;
            cmd_o.word_sel    = WORD_PAT_A;
            cmd_o.victim_step = STEP_SHIFT;
            state_d           = S_VICTIM_NEXT;
          end
        end
      end
      S_DATA_WRITE: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = KIND_WRITE;
          cmd_o.off_sel  = OFF_ZERO;
          cmd_o.word_sel = WORD_WALK;
          state_d        = S_DATA_READ;
        end
      end
      S_DATA_READ: begin
        if (stat_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = KIND_READ;
          cmd_o.off_sel = OFF_ZERO;
          cmd_o.last    = 1'b1;
          state_d       = S_WAIT_DATA;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = KIND_FINISH;
          cmd_o.off_sel  = (fin_fail_q == FAIL_VICTIM) ? OFF_VICTIM : OFF_PROBE;
          cmd_o.status   = fin_status_q;
          cmd_o.fail_src = fin_fail_q;
          cmd_o.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fin_status_q <= STATUS_OK;
      fin_fail_q   <= FAIL_NONE;
    end else begin
      state_q      <= state_d;
      fin_status_q <= fin_status_d;
      fin_fail_q   <= fin_fail_d;
    end
  end

endmodule

// ===== sv/rbst_datapath.sv =====
// ----------------------------------------------------------------------------
// RAM bus self-test datapath
// Configuration registers, probe/victim offsets, walking-one pattern, the
// address adder, read-data compare and the result register.
// ----------------------------------------------------------------------------
module rbst_datapath import rbst_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rbst_cmd_t              cmd_i,
  output rbst_stat_t             stat_o,
  input  logic [READ_DATA_W-1:0] read_data_i,
  rbst_cfg_if.sink               cfg_i,
  rbst_out_if.source             out_o
);

  localparam int unsigned WORD_BYTES = DATA_BITS / 8;
  // room for the first offset shifted one place past the top of the mask
  localparam int unsigned OFF_W = REGION_BYTES_W + $clog2(WORD_BYTES + 1);
  localparam int unsigned SUM_W = (ADDR_BITS > ACCESS_ADDRESS_W) ? ADDR_BITS : ACCESS_ADDRESS_W;
  localparam logic [SUM_W-1:0] ADDR_MASK = {SUM_W{1'b1}} >> (SUM_W - ADDR_BITS);
  localparam logic [OFF_W-1:0] FIRST_OFF = OFF_W'(WORD_BYTES);
  localparam logic [DATA_BITS-1:0] PAT_A_D = PAT_A[DATA_BITS-1:0];
  localparam logic [DATA_BITS-1:0] PAT_5_D = PAT_5[DATA_BITS-1:0];
  localparam logic [DATA_BITS-1:0] WALK_ONE = DATA_BITS'(1);

  logic [BASE_ADDRESS_W-1:0] base_q;
  logic [REGION_BYTES_W-1:0] region_q;
  logic                      test_en_q;

  logic [OFF_W-1:0]     probe_q, probe_d;
  logic [OFF_W-1:0]     victim_q, victim_d;
  logic [DATA_BITS-1:0] walk_q, walk_d;

  logic [REGION_BYTES_W-1:0] region_mask;
  logic [OFF_W-1:0]          off_mux;
  logic [SUM_W-1:0]          addr_sum;
  logic [SUM_W-1:0]          addr;
  logic [DATA_BITS-1:0]      word_mux;
  logic [DATA_BITS-1:0]      rd;
  logic [FAIL_WORD_W-1:0]    fail_mux;

  logic                        out_valid_q;
  logic [ACCESS_KIND_W-1:0]    kind_q;
  logic [ACCESS_ADDRESS_W-1:0] address_q;
  logic [WRITE_WORD_W-1:0]     word_q;
  logic [RESULT_STATUS_W-1:0]  status_q;
  logic [FAIL_WORD_W-1:0]      fail_q;
  logic                        last_q;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      region_q  <= REGION_BYTES_RST;
      test_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_BASE_ADDRESS: base_q    <= BASE_ADDRESS_W'(cfg_i.write_data);
        REG_REGION_BYTES: region_q  <= REGION_BYTES_W'(cfg_i.write_data);
        REG_TEST_ENABLE:  test_en_q <= cfg_i.write_data[0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // offset, address and compare logic
  assign region_mask = region_q - REGION_BYTES_W'(1);
  assign rd          = DATA_BITS'(read_data_i);

  always_comb begin
    case (cmd_i.off_sel)
      OFF_PROBE:  off_mux = probe_q;
      OFF_VICTIM: off_mux = victim_q;
      default:    off_mux = '0;
    endcase
  end

  assign addr_sum = SUM_W'(base_q) + SUM_W'(off_mux) * SUM_W'(WORD_BYTES);
  assign addr     = addr_sum & ADDR_MASK;

  always_comb begin
    case (cmd_i.word_sel)
      WORD_ONE:   word_mux = WALK_ONE;
      WORD_PAT_A: word_mux = PAT_A_D;
      WORD_PAT_5: word_mux = PAT_5_D;
      WORD_WALK:  word_mux = walk_q;
      default:    word_mux = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.fail_src) inside
      FAIL_PROBE, FAIL_VICTIM: fail_mux = FAIL_WORD_W'(addr);
      FAIL_WALK:               fail_mux = FAIL_WORD_W'(walk_q);
      default:                 fail_mux = '0;
    endcase
  end

  assign stat_o.test_en         = test_en_q;
  assign stat_o.probe_in        = |(probe_q[REGION_BYTES_W-1:0] & region_mask);
  assign stat_o.victim_in       = |(victim_q[REGION_BYTES_W-1:0] & region_mask);
  assign stat_o.rd_eq_pat       = (rd == PAT_A_D);
  assign stat_o.rd_eq_walk      = (rd == walk_q);
  assign stat_o.probe_eq_victim = (probe_q == victim_q);
  assign stat_o.walk_top        = walk_q[DATA_BITS-1];
  assign stat_o.out_free        = !out_valid_q || out_o.ready;

  // offset and pattern registers
  always_comb begin
    case (cmd_i.probe_step)
      STEP_FIRST: probe_d = FIRST_OFF;
      STEP_SHIFT: probe_d = probe_q << 1;
      default:    probe_d = probe_q;
    endcase
    case (cmd_i.victim_step)
      STEP_FIRST: victim_d = FIRST_OFF;
      STEP_SHIFT: victim_d = victim_q << 1;
      default:    victim_d = victim_q;
    endcase
    case (cmd_i.walk_step)
      STEP_FIRST: walk_d = WALK_ONE;
      STEP_SHIFT: walk_d = walk_q << 1;
      default:    walk_d = walk_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q  <= '0;
      victim_q <= '0;
      walk_q   <= WALK_ONE;
    end else begin
      probe_q  <= probe_d;
      victim_q <= victim_d;
      walk_q   <= walk_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q    <= cmd_i.kind;
      address_q <= (cmd_i.kind == KIND_FINISH) ? '0 : ACCESS_ADDRESS_W'(addr);
      word_q    <= WRITE_WORD_W'(word_mux);
      status_q  <= cmd_i.status;
      fail_q    <= fail_mux;
      last_q    <= cmd_i.last;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.access_kind    = kind_q;
  assign out_o.access_address = address_q;
  assign out_o.write_word     = word_q;
  assign out_o.result_status  = status_q;
  assign out_o.fail_word      = fail_q;
  assign out_o.last_of_run    = last_q;

endmodule

// ===== sim/ram_bus_self_test_sequencer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RAM bus self-test sequencer testbench
// A directed table and then random test sessions drive start and read-data
// requests, with random gaps on both channels. A model of the sequencer
// predicts every write, read and finish request, and each one is compared
// with the expected request.
// ----------------------------------------------------------------------------
module ram_bus_self_test_sequencer_test;
  import rbst_pkg::*;

  localparam int unsigned WORD_BYTES = DATA_BITS_DEF / 8;
  localparam logic [25:0] FIRST_OFF = 26'(WORD_BYTES);
  localparam logic [READ_DATA_W-1:0] WORD_PATTERN = PAT_A[READ_DATA_W-1:0];
  localparam logic [READ_DATA_W-1:0] WORD_ANTI = PAT_5[READ_DATA_W-1:0];
  localparam int MAX_RUN = 64;
  localparam int DRAIN_CYCLES = 6;
  localparam int ITEM_TARGET = 460;
  localparam int TIMEOUT_NS = 30_000_000;

  typedef enum logic [1:0] {
    TEST_IDLE,
    TEST_STUCK_HIGH,
    TEST_STUCK_LOW,
    TEST_DATA_WALK
  } test_phase_e;

  typedef struct packed {
    kind_e                       kind;
    logic [ACCESS_ADDRESS_W-1:0] addr;
    logic [WRITE_WORD_W-1:0]     word;
    status_e                     status;
    logic [FAIL_WORD_W-1:0]      fail;
    logic                        last;
  } access_t;

  typedef struct packed {
    logic                   is_cfg;
    reg_index_e             idx;
    logic [CFG_DATA_W-1:0]  value;
    op_e                    op;
    logic [READ_DATA_W-1:0] rd;
    logic                   typed;
    access_t                want;
  } stim_row_t;

  localparam access_t NONE = '{KIND_WRITE, '0, '0, STATUS_OK, '0, 1'b0};
  localparam access_t FIN_OK = '{KIND_FINISH, '0, '0, STATUS_OK, '0, 1'b1};
  localparam access_t FIN_WALK_4 = '{KIND_FINISH, '0, '0, STATUS_DATA_FAULT, 24'h000004, 1'b1};
  localparam access_t FIN_ADDR_4 = '{KIND_FINISH, '0, '0, STATUS_ADDR_FAULT, 24'h000004, 1'b1};
  localparam access_t FIN_ADDR_8 = '{KIND_FINISH, '0, '0, STATUS_ADDR_FAULT, 24'h000008, 1'b1};
  localparam access_t FIN_ADDR_1004 =
    '{KIND_FINISH, '0, '0, STATUS_ADDR_FAULT, 24'h001004, 1'b1};

  localparam stim_row_t DIRECTED [27] = '{
    // read data while idle is dropped
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'hFFFF, 1'b0, NONE},
    '{1'b1, REG_TEST_ENABLE, 25'd0, OP_START, '0, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_START, 16'h0000, 1'b1, FIN_OK},
    // empty offset set at the top of the address space, then a walk fault
    '{1'b1, REG_TEST_ENABLE, 25'd1, OP_START, '0, 1'b0, NONE},
    '{1'b1, REG_BASE_ADDRESS, 25'hFFFFFF, OP_START, '0, 1'b0, NONE},
    '{1'b1, REG_REGION_BYTES, 25'd2, OP_START, '0, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_START, 16'h0000, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'h0001, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'h0002, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'h0000, 1'b1, FIN_WALK_4},
    // size zero: every offset bit in range, stuck-high fault at once
    '{1'b1, REG_BASE_ADDRESS, 25'd0, OP_START, '0, 1'b0, NONE},
    '{1'b1, REG_REGION_BYTES, 25'd0, OP_START, '0, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_START, 16'h0000, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'h0000, 1'b1, FIN_ADDR_4},
    // largest region, restart while running
    '{1'b1, REG_REGION_BYTES, 25'h1000000, OP_START, '0, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_START, 16'hFFFF, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_START, 16'h0000, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'hAAAA, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'hAAAB, 1'b1, FIN_ADDR_8},
    // victim read is not compared, the next probe is
    '{1'b1, REG_BASE_ADDRESS, 25'h001000, OP_START, '0, 1'b0, NONE},
    '{1'b1, REG_REGION_BYTES, 25'd16, OP_START, '0, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_START, 16'h0000, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'hAAAA, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'hAAAA, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'hAAAA, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'h5555, 1'b0, NONE},
    '{1'b0, REG_BASE_ADDRESS, '0, OP_READ, 16'h0000, 1'b1, FIN_ADDR_1004}
  };

  logic clk = 1'b0;
  logic rst_n;

  rbst_in_if  in_ch ();
  rbst_out_if out_ch ();
  rbst_cfg_if cfg_ch ();

  ram_bus_self_test_sequencer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #6 clk = ~clk;

  // model state and registers
  logic [BASE_ADDRESS_W-1:0] base_reg = '0;
  logic [REGION_BYTES_W-1:0] region_reg = REGION_BYTES_RST;
  logic                      enable_reg = 1'b1;
  test_phase_e               test_phase = TEST_IDLE;
  logic [25:0]               probe_off = '0;
  logic [25:0]               victim_off = '0;
  logic [READ_DATA_W-1:0]    walk_word = 16'd1;

  access_t run_requests[$];
  access_t expected_requests[$];

  int      mismatch_count = 0;
  int      item_count = 0;
  int      in_gap_max = 12;
  int      out_stall_max = 12;
  logic    typed_on = 1'b0;
  access_t typed_want;

  function automatic logic in_region(logic [25:0] off);
    logic [REGION_BYTES_W-1:0] mask;
    mask = region_reg - 25'd1;
    return (off[24:0] & mask) != '0;
  endfunction

  function automatic logic [ACCESS_ADDRESS_W-1:0] addr_of(logic [25:0] off);
    logic [27:0] sum;
    sum = 28'(base_reg) + 28'(off) * 28'(WORD_BYTES);
    return sum[ACCESS_ADDRESS_W-1:0];
  endfunction

  function automatic void put(kind_e k, logic [ACCESS_ADDRESS_W-1:0] a,
                              logic [WRITE_WORD_W-1:0] w, status_e s,
                              logic [FAIL_WORD_W-1:0] f);
    access_t r;
    if (run_requests.size() >= MAX_RUN) return;
    r.kind = k;
    r.addr = a;
    r.word = w;
    r.status = s;
    r.fail = f;
    r.last = 1'b0;
    run_requests.push_back(r);
  endfunction

  function automatic void finish_test(status_e s, logic [FAIL_WORD_W-1:0] f);
    put(KIND_FINISH, '0, '0, s, f);
    test_phase = TEST_IDLE;
  endfunction

  function automatic void start_walk();
    walk_word = 16'd1;
    put(KIND_WRITE, addr_of('0), walk_word, STATUS_OK, '0);
    put(KIND_READ, addr_of('0), '0, STATUS_OK, '0);
    test_phase = TEST_DATA_WALK;
  endfunction

  function automatic void low_advance();
    // restore the victim and move on once its probes are used up
    while (!in_region(probe_off)) begin
      put(KIND_WRITE, addr_of(victim_off), WORD_PATTERN, STATUS_OK, '0);
      victim_off = victim_off << 1;
      if (!in_region(victim_off)) begin
        start_walk();
        return;
      end
      put(KIND_WRITE, addr_of(victim_off), WORD_ANTI, STATUS_OK, '0);
      probe_off = FIRST_OFF;
    end
    put(KIND_READ, addr_of(probe_off), '0, STATUS_OK, '0);
    test_phase = TEST_STUCK_LOW;
  endfunction

  function automatic void high_advance();
    if (in_region(probe_off)) begin
      put(KIND_READ, addr_of(probe_off), '0, STATUS_OK, '0);
      test_phase = TEST_STUCK_HIGH;
      return;
    end
    put(KIND_WRITE, addr_of('0), WORD_PATTERN, STATUS_OK, '0);
    victim_off = FIRST_OFF;
    if (!in_region(victim_off)) begin
      start_walk();
      return;
    end
    put(KIND_WRITE, addr_of(victim_off), WORD_ANTI, STATUS_OK, '0);
    probe_off = FIRST_OFF;
    low_advance();
  endfunction

  function automatic void predict_requests(op_e op, logic [READ_DATA_W-1:0] rd);
    logic [25:0] off;
    run_requests.delete();
    if (op == OP_START) begin
      if (!enable_reg) begin
        finish_test(STATUS_OK, '0);
      end else begin
        for (off = FIRST_OFF; in_region(off); off = off << 1)
          put(KIND_WRITE, addr_of(off), WORD_PATTERN, STATUS_OK, '0);
        put(KIND_WRITE, addr_of('0), WORD_ANTI, STATUS_OK, '0);
        probe_off = FIRST_OFF;
        high_advance();
      end
    end else begin
      case (test_phase)
        TEST_STUCK_HIGH: begin
          if (rd != WORD_PATTERN) begin
            finish_test(STATUS_ADDR_FAULT, addr_of(probe_off));
          end else begin
            probe_off = probe_off << 1;
            high_advance();
          end
        end
        TEST_STUCK_LOW: begin
          if (rd != WORD_PATTERN && probe_off != victim_off) begin
            finish_test(STATUS_ADDR_FAULT, addr_of(victim_off));
          end else begin
            probe_off = probe_off << 1;
            low_advance();
          end
        end
        TEST_DATA_WALK: begin
          if (rd != walk_word) begin
            finish_test(STATUS_DATA_FAULT, FAIL_WORD_W'(walk_word));
          end else begin
            walk_word = walk_word << 1;
            if (walk_word == '0) begin
              walk_word = 16'd1;
              finish_test(STATUS_OK, '0);
            end else begin
              put(KIND_WRITE, addr_of('0), walk_word, STATUS_OK, '0);
              put(KIND_READ, addr_of('0), '0, STATUS_OK, '0);
            end
          end
        end
        default: test_phase = TEST_IDLE;
      endcase
    end
    if (run_requests.size() > 0) run_requests[run_requests.size()-1].last = 1'b1;
  endfunction

  // word a healthy memory would return for the pending read
  function automatic logic [READ_DATA_W-1:0] stored_word();
    case (test_phase)
      TEST_STUCK_HIGH: return WORD_PATTERN;
      TEST_STUCK_LOW:  return (probe_off == victim_off) ? WORD_ANTI : WORD_PATTERN;
      TEST_DATA_WALK:  return walk_word;
      default:         return READ_DATA_W'($urandom);
    endcase
  endfunction

  function automatic void check_request();
    access_t want;
    if (expected_requests.size() == 0) begin
      $error("unexpected request: access_kind %0d access_address %06h",
             out_ch.access_kind, out_ch.access_address);
      mismatch_count++;
      return;
    end
    want = expected_requests.pop_front();
    if (out_ch.access_kind !== want.kind) begin
      $error("access_kind: expected %0d, got %0d", want.kind, out_ch.access_kind);
      mismatch_count++;
    end
    if (out_ch.access_address !== want.addr) begin
      $error("access_address: expected %06h, got %06h", want.addr, out_ch.access_address);
      mismatch_count++;
    end
    if (out_ch.write_word !== want.word) begin
      $error("write_word: expected %04h, got %04h", want.word, out_ch.write_word);
      mismatch_count++;
    end
    if (out_ch.result_status !== want.status) begin
      $error("result_status: expected %0d, got %0d", want.status, out_ch.result_status);
      mismatch_count++;
    end
    if (out_ch.fail_word !== want.fail) begin
      $error("fail_word: expected %06h, got %06h", want.fail, out_ch.fail_word);
      mismatch_count++;
    end
    if (out_ch.last_of_run !== want.last) begin
      $error("last_of_run: expected %0b, got %0b", want.last, out_ch.last_of_run);
      mismatch_count++;
    end
  endfunction

  // valid stays high after a request; drop it only when the stream pauses
  task automatic send_item(op_e op, logic [READ_DATA_W-1:0] rd);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.read_data <= rd;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_requests(op, rd);
    if (typed_on) begin
      if (run_requests.size() > 0) run_requests[run_requests.size()-1] = typed_want;
      else run_requests.push_back(typed_want);
    end
    foreach (run_requests[i]) expected_requests.push_back(run_requests[i]);
  endtask

  task automatic in_release();
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(reg_index_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.reg_index  <= idx;
    cfg_ch.write_data <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      REG_BASE_ADDRESS: base_reg = value[BASE_ADDRESS_W-1:0];
      REG_REGION_BYTES: region_reg = value[REGION_BYTES_W-1:0];
      REG_TEST_ENABLE:  enable_reg = value[0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_ch.valid <= 1'b0;
  endtask

  // hold until all requests are out and the block has settled
  task automatic wait_idle();
    in_release();
    while (expected_requests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_session(logic first);
    int budget;
    int reads;
    int roll;
    logic [READ_DATA_W-1:0] rd;
    wait_idle();
    if (first || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       write_reg(REG_BASE_ADDRESS, 25'd0);
        1:       write_reg(REG_BASE_ADDRESS, 25'hFFFFFF);
        default: write_reg(REG_BASE_ADDRESS, 25'($urandom_range(0, 24'hFFFFFF)));
      endcase
    end
    if (first || $urandom_range(0, 1) == 0) begin
      // keep regions small so the stuck-low loop stays short
      case ($urandom_range(0, 9))
        0:       write_reg(REG_REGION_BYTES, 25'd0);
        1:       write_reg(REG_REGION_BYTES, 25'h1000000);
        2:       write_reg(REG_REGION_BYTES, 25'($urandom));
        3, 4:    write_reg(REG_REGION_BYTES, 25'($urandom_range(1, 128)));
        default: write_reg(REG_REGION_BYTES, 25'd1 << $urandom_range(0, 6));
      endcase
    end
    if (first || $urandom_range(0, 1) == 0)
      write_reg(REG_TEST_ENABLE, 25'($urandom_range(0, 5) != 0));
    cfg_release();

    case ($urandom_range(0, 2))
      0:       in_gap_max = 0;
      1:       in_gap_max = 3;
      default: in_gap_max = 12;
    endcase
    case ($urandom_range(0, 2))
      0:       out_stall_max = 0;
      1:       out_stall_max = 3;
      default: out_stall_max = 12;
    endcase

    if ($urandom_range(0, 3) == 0) send_item(OP_READ, READ_DATA_W'($urandom));
    send_item(OP_START, READ_DATA_W'($urandom));
    item_count++;
    budget = $urandom_range(20, 90);
    reads = 0;
    while (test_phase != TEST_IDLE) begin
      roll = $urandom_range(0, 99);
      rd = stored_word();
      // past the budget, corrupt a bit to end long sessions
      if (reads > budget || roll < 3) rd = rd ^ (16'd1 << $urandom_range(0, 15));
      else if (roll < 6) rd = READ_DATA_W'($urandom);
      if (roll >= 7 && roll < 13) begin
        in_release();
        do @(posedge clk); while (expected_requests.size() != 0);
      end
      if (roll == 6) send_item(OP_START, rd);
      else send_item(OP_READ, rd);
      reads++;
      item_count++;
    end
  endtask

  // result sink with random stalls
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_request();
        hold = $urandom_range(0, out_stall_max);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic prev_cfg;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_START;
    in_ch.read_data   <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= REG_BASE_ADDRESS;
    cfg_ch.write_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    prev_cfg = 1'b0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].value);
      end else begin
        if (prev_cfg) cfg_release();
        typed_on = DIRECTED[i].typed;
        typed_want = DIRECTED[i].want;
        send_item(DIRECTED[i].op, DIRECTED[i].rd);
        typed_on = 1'b0;
        item_count++;
      end
      prev_cfg = DIRECTED[i].is_cfg;
    end

    run_session(1'b1);
    while (item_count < ITEM_TARGET) run_session(1'b0);

    in_release();
    while (expected_requests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
